### hdl/cha_pkg.sv
// ----------------------------------------------------------------------------
// cha_pkg: shared types and constants for the constrained heading argmin
// Item layouts, register indexes and the range limits of the search.
// ----------------------------------------------------------------------------
`default_nettype none

package cha_pkg;

    localparam int unsigned MAX_COLUMNS = 1024;
    localparam int unsigned MAX_ENTRIES = 65536;

    localparam int unsigned CFG_IDX_W  = 8;
    localparam int unsigned CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_COLUMN_STEP = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FOV_LIMIT   = 8'd1;

    localparam logic [31:0] VALUE_NONE = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [31:0] difference;
        logic [9:0]  column;
        logic [15:0] entry_index;
        logic [15:0] view_heading;
        logic [15:0] route_heading;
        logic        first;
        logic        last;
    } t_in_item;

    typedef struct packed {
        logic [15:0] best_heading;
        logic [15:0] best_entry;
        logic [31:0] lowest_value;
        logic        found;
    } t_out_item;

    // candidate passed from the heading stage to the search stage
    typedef struct packed {
        logic [31:0] difference;
        logic [15:0] entry_index;
        logic [15:0] heading;
        logic        ok;
        logic        first;
        logic        last;
    } t_cand;

endpackage

`default_nettype wire

### hdl/cha_channels.sv
// ----------------------------------------------------------------------------
// cha_channels: valid/ready channels of the constrained heading argmin
// Input item, result item and configuration write channels.
// ----------------------------------------------------------------------------
`default_nettype none

interface cha_in_if;
    logic              valid;
    logic              ready;
    cha_pkg::t_in_item payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface cha_out_if;
    logic               valid;
    logic               ready;
    cha_pkg::t_out_item payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface cha_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [cha_pkg::CFG_IDX_W-1:0]  index;
    logic [cha_pkg::CFG_DATA_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### hdl/cha_heading.sv
// ----------------------------------------------------------------------------
// cha_heading: candidate heading and field-of-view test
// Registers the input beat, forms view + column * step rounded to 2^-16 turn,
// tests the shortest angle to the route and registers the candidate.
// ----------------------------------------------------------------------------
`default_nettype none

module cha_heading (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    cha_in_if.sink             i_in,
    input  wire logic [31:0]   i_column_step,
    input  wire logic [15:0]   i_fov_limit,
    output cha_pkg::t_cand     o_cand,
    output logic               o_cand_valid,
    input  wire logic          i_cand_ready
);

    logic              r_s1_v;
    cha_pkg::t_in_item r_s1;
    logic              r_s2_v;
    cha_pkg::t_cand    r_s2;

    logic              s2_free;
    logic              s1_go;
    logic              in_acc;

    logic [41:0]       prod;
    logic [31:0]       rnd;
    logic [15:0]       heading;
    logic [15:0]       delta;
    logic [16:0]       mag;
    logic              in_range;
    cha_pkg::t_cand    n_s2;

    assign s2_free    = !r_s2_v || i_cand_ready;
    assign s1_go      = r_s1_v && s2_free;
    assign i_in.ready = !r_s1_v || s2_free;
    assign in_acc     = i_in.valid && i_in.ready;

    always_comb begin
        prod     = 42'(r_s1.column) * 42'(i_column_step);
        rnd      = prod[31:0] + 32'h0000_8000;
        heading  = r_s1.view_heading + rnd[31:16];
        delta    = heading - r_s1.route_heading;
        // half a turn comes out as 32768
        mag      = delta[15] ? (17'h1_0000 - {1'b0, delta}) : {1'b0, delta};
        in_range = (32'(r_s1.column) < 32'(cha_pkg::MAX_COLUMNS)) &&
                   (33'(r_s1.entry_index) < 33'(cha_pkg::MAX_ENTRIES));
        n_s2.difference  = r_s1.difference;
        n_s2.entry_index = r_s1.entry_index;
        n_s2.heading     = heading;
        n_s2.ok          = in_range && (mag < {1'b0, i_fov_limit});
        n_s2.first       = r_s1.first;
        n_s2.last        = r_s1.last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
        end else begin
            if (in_acc) begin
                r_s1_v <= 1'b1;
            end else if (s1_go) begin
                r_s1_v <= 1'b0;
            end
            if (s1_go) begin
                r_s2_v <= 1'b1;
            end else if (i_cand_ready) begin
                r_s2_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1 <= i_in.payload;
        end
        if (s1_go) begin
            r_s2 <= n_s2;
        end
    end

    assign o_cand       = r_s2;
    assign o_cand_valid = r_s2_v;

endmodule

`default_nettype wire

### hdl/cha_best.sv
// ----------------------------------------------------------------------------
// cha_best: running minimum and result register
// Keeps the best accepted candidate of the current search and registers
// the result beat when a last candidate goes through.
// ----------------------------------------------------------------------------
`default_nettype none

module cha_best (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire cha_pkg::t_cand i_cand,
    input  wire logic          i_cand_valid,
    output logic               o_cand_ready,
    cha_out_if.source          o_out
);

    cha_pkg::t_out_item r_best;
    cha_pkg::t_out_item base;
    cha_pkg::t_out_item n_best;
    logic               r_o_v;
    cha_pkg::t_out_item r_o;
    logic               out_free;
    logic               cand_go;
    logic               take;

    assign out_free     = !r_o_v || o_out.ready;
    // only a last beat needs the result register
    assign o_cand_ready = !i_cand.last || out_free;
    assign cand_go      = i_cand_valid && o_cand_ready;

    always_comb begin
        if (i_cand.first) begin
            base.best_heading = 16'd0;
            base.best_entry   = 16'd0;
            base.lowest_value = cha_pkg::VALUE_NONE;
            base.found        = 1'b0;
        end else begin
            base = r_best;
        end
        take = i_cand.ok && (i_cand.difference < base.lowest_value);
        if (take) begin
            n_best.best_heading = i_cand.heading;
            n_best.best_entry   = i_cand.entry_index;
            n_best.lowest_value = i_cand.difference;
            n_best.found        = 1'b1;
        end else begin
            n_best = base;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best.best_heading <= 16'd0;
            r_best.best_entry   <= 16'd0;
            r_best.lowest_value <= cha_pkg::VALUE_NONE;
            r_best.found        <= 1'b0;
            r_o_v               <= 1'b0;
        end else begin
            if (cand_go) begin
                r_best <= n_best;
            end
            if (cand_go && i_cand.last) begin
                r_o_v <= 1'b1;
            end else if (o_out.ready) begin
                r_o_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (cand_go && i_cand.last) begin
            r_o <= n_best;
        end
    end

    assign o_out.valid   = r_o_v;
    assign o_out.payload = r_o;

endmodule

`default_nettype wire

### hdl/constrained_heading_argmin_top.sv
// ----------------------------------------------------------------------------
// constrained_heading_argmin_top: field-of-view constrained heading argmin
// Streams difference beats, keeps the lowest one whose heading lies within
// the field of view of the route, and emits the best match on a last beat.
// ----------------------------------------------------------------------------
//  channel  dir  handshake      payload
//  i_in     in   valid/ready    difference, column, entry, headings, first, last
//  o_out    out  valid/ready    best_heading, best_entry, lowest_value, found
//  i_cfg    in   valid/ready    index (0 column_step, 1 fov_limit), data
//
//  One beat per cycle sustained; only a last beat waits on a full result
//  register, other beats pass. A result beat passes the input, candidate and
//  result registers after its last beat. Stages: input register, heading
//  multiply and angle test, running-minimum compare into the result register.
//  Synchronous active-low reset clears the search and both registers.
//  Configuration writes are always taken (ready held high).
// ----------------------------------------------------------------------------
`default_nettype none

module constrained_heading_argmin_top (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    cha_in_if.sink    i_in,
    cha_out_if.source o_out,
    cha_cfg_if.sink   i_cfg
);

    logic [31:0]    r_column_step;
    logic [15:0]    r_fov_limit;
    cha_pkg::t_cand cand;
    logic           cand_valid;
    logic           cand_ready;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_column_step <= 32'd0;
            r_fov_limit   <= 16'd0;
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (i_cfg.index)
                cha_pkg::CFG_COLUMN_STEP: r_column_step <= i_cfg.data;
                cha_pkg::CFG_FOV_LIMIT:   r_fov_limit   <= i_cfg.data[15:0];
                default: ;
            endcase
        end
    end

    cha_heading u_heading (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in          (i_in),
        .i_column_step (r_column_step),
        .i_fov_limit   (r_fov_limit),
        .o_cand        (cand),
        .o_cand_valid  (cand_valid),
        .i_cand_ready  (cand_ready)
    );

    cha_best u_best (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cand       (cand),
        .i_cand_valid (cand_valid),
        .o_cand_ready (cand_ready),
        .o_out        (o_out)
    );

endmodule

`default_nettype wire

### hdl/cha_checker.sv
// ----------------------------------------------------------------------------
// cha_checker: port-level checks for the constrained heading argmin
// Result beat consistency and output handshake checks, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module cha_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_out_valid,
    input wire logic        i_out_ready,
    input wire logic [15:0] i_best_heading,
    input wire logic [15:0] i_best_entry,
    input wire logic [31:0] i_lowest_value,
    input wire logic        i_found
);

    // reset empties the result register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result beat present after reset");

    // an empty search reports the cleared state
    a_none_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_found) |->
            (i_lowest_value == 32'hFFFF_FFFF && i_best_heading == 16'd0 &&
             i_best_entry == 16'd0))
        else $error("not found but best fields not cleared");

    // an all-ones difference is never accepted
    a_found_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_found) |-> (i_lowest_value != 32'hFFFF_FFFF))
        else $error("found with all-ones value");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_best_heading) && $stable(i_best_entry) &&
             $stable(i_lowest_value) && $stable(i_found)))
        else $error("stalled result beat changed");

endmodule

bind constrained_heading_argmin_top cha_checker u_cha_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_best_heading (o_out.payload.best_heading),
    .i_best_entry   (o_out.payload.best_entry),
    .i_lowest_value (o_out.payload.lowest_value),
    .i_found        (o_out.payload.found)
);

`default_nettype wire
